FILE: hw/rtl/dqpb_pkg.sv
package dqpb_pkg;

  // default build figures
  localparam int BUFFER_BYTES_DEF = 512;
  localparam int MAX_LABEL_DEF    = 63;
  localparam int CMD_DEPTH_DEF    = 4;

  // fixed message layout
  localparam int          HEADER_BYTES = 12;
  localparam logic [15:0] FLAGS_RD     = 16'h0100;
  localparam logic [15:0] QD_COUNT     = 16'h0001;
  localparam logic [15:0] INET_CLASS   = 16'h0001;
  localparam logic [7:0]  DOT_CHAR     = 8'h2e;
  localparam int          LABEL_W      = 7;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_LONG     = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  typedef struct packed {
    logic [7:0]  name_char;
    logic        first_char;
    logic        last_char;
    logic [15:0] query_type;
  } item_t;

  typedef struct packed {
    logic        write_valid;
    logic [8:0]  write_addr;
    logic [7:0]  write_byte;
    logic        packet_done;
    logic [1:0]  status;
    logic [9:0]  packet_length;
  } result_t;

  // classified work for one accepted character, front to back
  typedef struct packed {
    logic               hdr;
    logic [15:0]        id;
    logic               dot;
    logic [8:0]         dot_addr;
    logic [LABEL_W-1:0] dot_len;
    logic               chr;
    logic [8:0]         chr_addr;
    logic [7:0]         ch;
    logic               trl;
    logic [8:0]         lab_addr;
    logic [LABEL_W-1:0] lab_len;
    logic [9:0]         pos;
    logic [15:0]        qtype;
    logic               err_done;
    logic [1:0]         err;
  } command_t;

endpackage

FILE: hw/rtl/dqpb_front.sv
module dqpb_front #(
  parameter int BUFFER_BYTES = dqpb_pkg::BUFFER_BYTES_DEF,
  parameter int MAX_LABEL    = dqpb_pkg::MAX_LABEL_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [15:0]        cfg_data,
  input  logic               accept,
  input  dqpb_pkg::item_t    item,
  output logic               cmd_push,
  output dqpb_pkg::command_t cmd
);

  localparam int PW = $clog2(BUFFER_BYTES + 6);
  localparam logic [PW-1:0] BUF_END = PW'(BUFFER_BYTES);

  logic [15:0]                  query_id;
  logic [PW-1:0]                write_pos, write_pos_next;
  logic [PW-1:0]                label_start, label_start_next;
  logic [dqpb_pkg::LABEL_W-1:0] label_count, label_count_next;
  logic [1:0]                   error_code, error_code_next;
  logic                         pending_dot, pending_dot_next;
  logic                         active;

  // walk one character through header, label close, char and trailer or error report
  always_comb begin
    cmd              = '0;
    active           = item.first_char || (write_pos != '0);
    write_pos_next   = write_pos;
    label_start_next = label_start;
    label_count_next = label_count;
    error_code_next  = error_code;
    pending_dot_next = pending_dot;

    if (item.first_char) begin
      cmd.hdr          = 1'b1;
      cmd.id           = query_id;
      label_start_next = PW'(dqpb_pkg::HEADER_BYTES);
      write_pos_next   = PW'(dqpb_pkg::HEADER_BYTES + 1);
      label_count_next = '0;
      error_code_next  = dqpb_pkg::ST_OK;
      pending_dot_next = 1'b0;
    end

    // a held dot closes the previous label
    if (error_code_next == dqpb_pkg::ST_OK && pending_dot_next) begin
      if (write_pos_next >= BUF_END) begin
        error_code_next = dqpb_pkg::ST_OVERFLOW;
      end else begin
        cmd.dot          = 1'b1;
        cmd.dot_addr     = 9'(label_start_next);
        cmd.dot_len      = label_count_next;
        label_start_next = write_pos_next;
        write_pos_next   = write_pos_next + PW'(1);
        label_count_next = '0;
        pending_dot_next = 1'b0;
      end
    end

    // the character itself
    if (error_code_next == dqpb_pkg::ST_OK) begin
      if (item.name_char == dqpb_pkg::DOT_CHAR) begin
        if (!item.last_char) begin
          pending_dot_next = 1'b1;
        end
      end else if (label_count_next >= dqpb_pkg::LABEL_W'(MAX_LABEL)) begin
        error_code_next = dqpb_pkg::ST_LONG;
      end else if (write_pos_next >= BUF_END) begin
        error_code_next = dqpb_pkg::ST_OVERFLOW;
      end else begin
        cmd.chr          = 1'b1;
        cmd.chr_addr     = 9'(write_pos_next);
        cmd.ch           = item.name_char;
        write_pos_next   = write_pos_next + PW'(1);
        label_count_next = label_count_next + dqpb_pkg::LABEL_W'(1);
      end
    end

    // trailer or error report closes the packet
    if (item.last_char) begin
      if (error_code_next == dqpb_pkg::ST_OK && (write_pos_next + PW'(5)) > BUF_END) begin
        error_code_next = dqpb_pkg::ST_OVERFLOW;
      end
      if (error_code_next == dqpb_pkg::ST_OK) begin
        cmd.trl      = 1'b1;
        cmd.lab_addr = 9'(label_start_next);
        cmd.lab_len  = label_count_next;
        cmd.pos      = 10'(write_pos_next);
        cmd.qtype    = item.query_type;
      end else begin
        cmd.err_done = 1'b1;
        cmd.err      = error_code_next;
      end
      write_pos_next   = '0;
      label_start_next = '0;
      label_count_next = '0;
      pending_dot_next = 1'b0;
    end

    cmd_push = accept && active && (cmd.hdr || cmd.dot || cmd.chr || cmd.trl || cmd.err_done);
  end

  // name state and id counter
  always_ff @(posedge clk) begin
    if (rst) begin
      query_id    <= '0;
      write_pos   <= '0;
      label_start <= '0;
      label_count <= '0;
      error_code  <= dqpb_pkg::ST_OK;
      pending_dot <= 1'b0;
    end else begin
      if (accept && active) begin
        write_pos   <= write_pos_next;
        label_start <= label_start_next;
        label_count <= label_count_next;
        error_code  <= error_code_next;
        pending_dot <= pending_dot_next;
        if (item.first_char) begin
          query_id <= query_id + 16'd1;
        end
      end
      if (cfg_write) begin
        query_id <= cfg_data;
      end
    end
  end

endmodule

FILE: hw/rtl/dqpb_cmd_fifo.sv
module dqpb_cmd_fifo #(
  parameter int DEPTH = dqpb_pkg::CMD_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr,
  input  dqpb_pkg::command_t wr_data,
  input  logic               rd,
  output dqpb_pkg::command_t head,
  output logic               full,
  output logic               empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  dqpb_pkg::command_t slots [DEPTH];
  logic [AW-1:0]      wr_ptr, rd_ptr;
  logic [CW-1:0]      count;
  logic               do_wr, do_rd;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign head  = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

FILE: hw/rtl/dqpb_back.sv
module dqpb_back (
  input  logic               clk,
  input  logic               rst,
  input  dqpb_pkg::command_t head,
  input  logic               head_empty,
  output logic               head_pop,
  input  logic               pop,
  output logic               empty,
  output dqpb_pkg::result_t  result
);

  typedef enum logic [2:0] {
    PH_HDR,
    PH_DOT,
    PH_CHR,
    PH_TRL,
    PH_ERR,
    PH_END
  } phase_t;

  phase_t            phase, cur_phase, nxt_phase;
  logic [3:0]        idx, cur_idx;
  logic              busy;
  logic              out_valid;
  logic              advance;
  logic              phase_last;
  dqpb_pkg::result_t word;

  // next phase of a command that has work after the given one
  function automatic phase_t phase_after(phase_t p, dqpb_pkg::command_t c);
    if (p == PH_HDR && c.dot) return PH_DOT;
    if ((p == PH_HDR || p == PH_DOT) && c.chr) return PH_CHR;
    if (p != PH_TRL && p != PH_ERR && c.trl) return PH_TRL;
    if (p != PH_TRL && p != PH_ERR && c.err_done) return PH_ERR;
    return PH_END;
  endfunction

  assign empty   = !out_valid;
  assign advance = !out_valid || pop;

  // sequence position and the word it produces
  always_comb begin
    cur_phase  = busy ? phase : (head.hdr ? PH_HDR : phase_after(PH_HDR, head));
    cur_idx    = busy ? idx : 4'd0;
    phase_last = 1'b1;
    word       = '0;
    case (cur_phase)
      PH_HDR: begin
        phase_last       = (cur_idx == 4'd11);
        word.write_valid = 1'b1;
        word.write_addr  = 9'(cur_idx);
        case (cur_idx)
          4'd0:    word.write_byte = head.id[15:8];
          4'd1:    word.write_byte = head.id[7:0];
          4'd2:    word.write_byte = dqpb_pkg::FLAGS_RD[15:8];
          4'd3:    word.write_byte = dqpb_pkg::FLAGS_RD[7:0];
          4'd4:    word.write_byte = dqpb_pkg::QD_COUNT[15:8];
          4'd5:    word.write_byte = dqpb_pkg::QD_COUNT[7:0];
          default: word.write_byte = 8'd0;
        endcase
      end
      PH_DOT: begin
        word.write_valid = 1'b1;
        word.write_addr  = head.dot_addr;
        word.write_byte  = 8'(head.dot_len);
      end
      PH_CHR: begin
        word.write_valid = 1'b1;
        word.write_addr  = head.chr_addr;
        word.write_byte  = head.ch;
      end
      PH_TRL: begin
        phase_last       = (cur_idx == 4'd5);
        word.write_valid = 1'b1;
        case (cur_idx)
          4'd0: begin
            word.write_addr = head.lab_addr;
            word.write_byte = 8'(head.lab_len);
          end
          4'd1: begin
            word.write_addr = 9'(head.pos);
            word.write_byte = 8'd0;
          end
          4'd2: begin
            word.write_addr = 9'(head.pos + 10'd1);
            word.write_byte = head.qtype[15:8];
          end
          4'd3: begin
            word.write_addr = 9'(head.pos + 10'd2);
            word.write_byte = head.qtype[7:0];
          end
          4'd4: begin
            word.write_addr = 9'(head.pos + 10'd3);
            word.write_byte = dqpb_pkg::INET_CLASS[15:8];
          end
          default: begin
            word.write_addr    = 9'(head.pos + 10'd4);
            word.write_byte    = dqpb_pkg::INET_CLASS[7:0];
            word.packet_done   = 1'b1;
            word.status        = dqpb_pkg::ST_OK;
            word.packet_length = head.pos + 10'd5;
          end
        endcase
      end
      PH_ERR: begin
        word.packet_done = 1'b1;
        word.status      = head.err;
      end
      default: begin
        word = '0;
      end
    endcase
    nxt_phase = phase_last ? phase_after(cur_phase, head) : cur_phase;
    head_pop  = advance && !head_empty && (nxt_phase == PH_END);
  end

  // sequencer state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      phase     <= PH_HDR;
      idx       <= 4'd0;
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= !head_empty;
      if (!head_empty) begin
        result <= word;
        if (nxt_phase == PH_END) begin
          busy <= 1'b0;
        end else begin
          busy  <= 1'b1;
          phase <= nxt_phase;
          idx   <= phase_last ? 4'd0 : cur_idx + 4'd1;
        end
      end
    end
  end

endmodule

FILE: hw/rtl/dns_query_packet_builder.sv
// DNS query packet builder
// Input queue side: present one name character on item with push; it is taken
// on a clock edge where push is high and full is low. first_char opens a packet,
// last_char closes it and carries query_type. cfg_write loads the query id
// counter from cfg_data; write it only while no name is in flight.
// Result queue side: while empty is low, result holds the oldest byte write;
// pop on a clock edge with empty low takes it.
// A character is classified in the cycle it is taken and queued as at most one
// command; the queue and then the output register carry it to the result port.
// Throughput: input accepts one character per cycle while the command queue
// has room. The result sequencer emits one word per cycle when pop allows it:
// a plain character gives one write, a closed label 2, a header 12 more and a
// trailer 6 more, up to 19 words per item; the result port sets the sustained rate.
// When pop is held low the output register keeps its word, the sequencer stops,
// and full rises only after the command queue fills.
// Synchronous reset empties both queues, clears the name state and sets the
// query id to zero.
module dns_query_packet_builder #(
  parameter int BUFFER_BYTES = dqpb_pkg::BUFFER_BYTES_DEF,
  parameter int MAX_LABEL    = dqpb_pkg::MAX_LABEL_DEF,
  parameter int CMD_DEPTH    = dqpb_pkg::CMD_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [15:0]       cfg_data,
  input  logic              push,
  output logic              full,
  input  dqpb_pkg::item_t   item,
  output logic              empty,
  input  logic              pop,
  output dqpb_pkg::result_t result
);

  logic               accept;
  logic               cmd_push;
  logic               cmd_pop;
  logic               cmd_empty;
  dqpb_pkg::command_t cmd;
  dqpb_pkg::command_t head;

  assign accept = push && !full;

  // classification front
  dqpb_front #(
    .BUFFER_BYTES (BUFFER_BYTES),
    .MAX_LABEL    (MAX_LABEL)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .item      (item),
    .cmd_push  (cmd_push),
    .cmd       (cmd)
  );

  // command queue between the halves
  dqpb_cmd_fifo #(
    .DEPTH (CMD_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr      (cmd_push),
    .wr_data (cmd),
    .rd      (cmd_pop),
    .head    (head),
    .full    (full),
    .empty   (cmd_empty)
  );

  // byte write sequencer
  dqpb_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_empty (cmd_empty),
    .head_pop   (cmd_pop),
    .pop        (pop),
    .empty      (empty),
    .result     (result)
  );

endmodule

FILE: hw/rtl/dqpb_checker.sv
module dqpb_checker (
  input logic              clk,
  input logic              rst,
  input logic              empty,
  input logic              pop,
  input dqpb_pkg::result_t result
);

  // reset leaves nothing to read
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  // a stalled word stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("result word changed while stalled");

  // a good finish is a real write with a length, a bad one writes nothing
  a_done_ok: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.packet_done && result.status == dqpb_pkg::ST_OK)
      |-> (result.write_valid && result.packet_length != 10'd0))
    else $error("ok finish without write or length");

  a_done_err: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.status != dqpb_pkg::ST_OK)
      |-> (result.packet_done && !result.write_valid && result.packet_length == 10'd0))
    else $error("error word malformed");

  // words before the finish carry no status and no length
  a_mid_clean: assert property (@(posedge clk) disable iff (rst)
    (!empty && !result.packet_done)
      |-> (result.write_valid && result.packet_length == 10'd0))
    else $error("intermediate word malformed");

endmodule

bind dns_query_packet_builder dqpb_checker u_chk (
  .clk    (clk),
  .rst    (rst),
  .empty  (empty),
  .pop    (pop),
  .result (result)
);

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam int BUF_BYTES = dqpb_pkg::BUFFER_BYTES_DEF;
  localparam int LABEL_MAX = dqpb_pkg::MAX_LABEL_DEF;

  // one directed row: input item plus hand-typed outcome where obvious
  typedef struct {
    dqpb_pkg::item_t it;
    int              words;
    bit              done_typed;
    logic [1:0]      st;
    logic [9:0]      plen;
  } probe_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_write = 1'b0;
  logic [15:0]       cfg_data = 16'h0000;
  logic              push = 1'b0;
  logic              full;
  dqpb_pkg::item_t   item = '0;
  logic              empty;
  logic              pop = 1'b0;
  dqpb_pkg::result_t result;

  // encoder shadow state
  logic [15:0] next_id = 16'h0000;
  int          fill_pos = 0;
  int          len_byte_pos = 0;
  int          label_len = 0;
  logic [1:0]  name_err = dqpb_pkg::ST_OK;
  bit          dot_held = 1'b0;

  dqpb_pkg::result_t expected_words[$];
  logic [7:0]        name_buf[$];
  probe_t            probes[$];
  int                fail_count = 0;
  bit                calm = 1'b0;
  logic              hold_req = 1'b0;

  dns_query_packet_builder dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .push      (push),
    .full      (full),
    .item      (item),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(20_000_000);
    $display("FAILURE");
    $finish;
  end

  // idle length: mostly none, sometimes short, rarely long
  function automatic int gap_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic logic [7:0] pick_char();
    if ($urandom_range(0, 99) < 85) return 8'("a" + $urandom_range(0, 25));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic probe_t row(input logic [7:0] ch, input bit f, input bit l,
                                 input logic [15:0] q, input int words,
                                 input bit done_typed, input logic [1:0] st,
                                 input logic [9:0] plen);
    probe_t p;
    p.it.name_char = ch;
    p.it.first_char = f;
    p.it.last_char = l;
    p.it.query_type = q;
    p.words = words;
    p.done_typed = done_typed;
    p.st = st;
    p.plen = plen;
    return p;
  endfunction

  task automatic put_byte(input int addr, input logic [7:0] b);
    dqpb_pkg::result_t w;
    w = '0;
    w.write_valid = 1'b1;
    w.write_addr = 9'(addr);
    w.write_byte = b;
    expected_words.push_back(w);
  endtask

  // expected buffer writes for one accepted character
  task automatic encode_char(input dqpb_pkg::item_t it, output int n_words);
    int base;
    bit is_dot;
    dqpb_pkg::result_t w;
    base = expected_words.size();
    is_dot = (it.name_char == dqpb_pkg::DOT_CHAR);
    if (it.first_char || fill_pos != 0) begin
      // header opens a new packet
      if (it.first_char) begin
        put_byte(0, next_id[15:8]);
        put_byte(1, next_id[7:0]);
        put_byte(2, dqpb_pkg::FLAGS_RD[15:8]);
        put_byte(3, dqpb_pkg::FLAGS_RD[7:0]);
        put_byte(4, dqpb_pkg::QD_COUNT[15:8]);
        put_byte(5, dqpb_pkg::QD_COUNT[7:0]);
        for (int a = 6; a < dqpb_pkg::HEADER_BYTES; a++) put_byte(a, 8'h00);
        next_id = next_id + 16'd1;
        len_byte_pos = dqpb_pkg::HEADER_BYTES;
        fill_pos = dqpb_pkg::HEADER_BYTES + 1;
        label_len = 0;
        name_err = dqpb_pkg::ST_OK;
        dot_held = 1'b0;
      end
      // held dot closes the previous label
      if (name_err == dqpb_pkg::ST_OK && dot_held) begin
        if (fill_pos >= BUF_BYTES) begin
          name_err = dqpb_pkg::ST_OVERFLOW;
        end else begin
          put_byte(len_byte_pos, 8'(label_len));
          len_byte_pos = fill_pos;
          fill_pos++;
          label_len = 0;
          dot_held = 1'b0;
        end
      end
      // the character itself
      if (name_err == dqpb_pkg::ST_OK) begin
        if (is_dot) begin
          if (!it.last_char) dot_held = 1'b1;
        end else if (label_len >= LABEL_MAX) begin
          name_err = dqpb_pkg::ST_LONG;
        end else if (fill_pos >= BUF_BYTES) begin
          name_err = dqpb_pkg::ST_OVERFLOW;
        end else begin
          put_byte(fill_pos, it.name_char);
          fill_pos++;
          label_len++;
        end
      end
      // trailer or error word
      if (it.last_char) begin
        if (name_err == dqpb_pkg::ST_OK && fill_pos + 5 > BUF_BYTES)
          name_err = dqpb_pkg::ST_OVERFLOW;
        w = '0;
        w.packet_done = 1'b1;
        if (name_err == dqpb_pkg::ST_OK) begin
          put_byte(len_byte_pos, 8'(label_len));
          put_byte(fill_pos, 8'h00);
          put_byte(fill_pos + 1, it.query_type[15:8]);
          put_byte(fill_pos + 2, it.query_type[7:0]);
          put_byte(fill_pos + 3, dqpb_pkg::INET_CLASS[15:8]);
          w.write_valid = 1'b1;
          w.write_addr = 9'(fill_pos + 4);
          w.write_byte = dqpb_pkg::INET_CLASS[7:0];
          w.status = dqpb_pkg::ST_OK;
          w.packet_length = 10'(fill_pos + 5);
        end else begin
          w.status = name_err;
        end
        expected_words.push_back(w);
        fill_pos = 0;
        len_byte_pos = 0;
        label_len = 0;
        dot_held = 1'b0;
      end
    end
    n_words = expected_words.size() - base;
  endtask

  task automatic report(input string fld, input int unsigned want, input int unsigned got);
    $error("%s: expected %0d, got %0d", fld, want, got);
    fail_count++;
  endtask

  task automatic check_word(input dqpb_pkg::result_t got);
    dqpb_pkg::result_t want;
    if (expected_words.size() == 0) begin
      $error("word with nothing expected: addr %0d byte %0h", got.write_addr, got.write_byte);
      fail_count++;
    end else begin
      want = expected_words.pop_front();
      if (got.write_valid !== want.write_valid)
        report("write_valid", want.write_valid, got.write_valid);
      if (got.write_addr !== want.write_addr)
        report("write_addr", want.write_addr, got.write_addr);
      if (got.write_byte !== want.write_byte)
        report("write_byte", want.write_byte, got.write_byte);
      if (got.packet_done !== want.packet_done)
        report("packet_done", want.packet_done, got.packet_done);
      if (got.status !== want.status)
        report("status", want.status, got.status);
      if (got.packet_length !== want.packet_length)
        report("packet_length", want.packet_length, got.packet_length);
    end
  endtask

  // offer one character until taken, then predict its writes
  task automatic send_char(input dqpb_pkg::item_t it, output int n_words);
    push <= 1'b1;
    item <= it;
    @(posedge clk);
    while (full) @(posedge clk);
    encode_char(it, n_words);
  endtask

  task automatic idle_sender();
    int g;
    g = gap_len();
    if (g > 0) begin
      push <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // send name_buf, closed with last_char or left open
  task automatic send_name(input bit close);
    dqpb_pkg::item_t it;
    int n;
    for (int i = 0; i < name_buf.size(); i++) begin
      if (i > 0) idle_sender();
      it.name_char = name_buf[i];
      it.first_char = (i == 0);
      it.last_char = close && (i == name_buf.size() - 1);
      it.query_type = 16'($urandom_range(0, 65535));
      send_char(it, n);
    end
  endtask

  task automatic make_name();
    int labels;
    int len;
    int r;
    name_buf.delete();
    labels = $urandom_range(1, 4);
    for (int k = 0; k < labels; k++) begin
      if (k > 0) name_buf.push_back(dqpb_pkg::DOT_CHAR);
      r = $urandom_range(0, 99);
      if (r < 84) len = $urandom_range(1, 8);
      else if (r < 91) len = 0;
      else if (r < 95) len = LABEL_MAX;
      else len = $urandom_range(LABEL_MAX + 1, LABEL_MAX + 3);
      for (int j = 0; j < len; j++) name_buf.push_back(pick_char());
    end
    if ($urandom_range(0, 4) == 0) name_buf.push_back(dqpb_pkg::DOT_CHAR);
    if (name_buf.size() == 0) name_buf.push_back(pick_char());
  endtask

  // mostly well-formed names, some noise and abandoned names
  task automatic run_random(input int n_items);
    int sent;
    int r;
    int n;
    dqpb_pkg::item_t it;
    sent = 0;
    while (sent < n_items) begin
      idle_sender();
      r = $urandom_range(0, 99);
      if (r < 8) begin
        it.name_char = pick_char();
        it.first_char = 1'b0;
        it.last_char = 1'($urandom_range(0, 1));
        it.query_type = 16'($urandom_range(0, 65535));
        send_char(it, n);
      end else begin
        make_name();
        send_name(r >= 15);
        sent += name_buf.size();
      end
    end
    idle_sender();
    make_name();
    send_name(1'b1);
  endtask

  // drain, wait out the pipeline, then load the id counter
  task automatic write_seed(input logic [15:0] v);
    push <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    next_id = v;
    cfg_write <= 1'b0;
  endtask

  // result side: check each popped word, random stalls and one long hold
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && pop && !empty) check_word(result);
      if (hold_req) begin
        hold_req <= 1'b0;
        stall_left = 300;
      end
      if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
        stall_left = gap_len();
      end
    end
  end

  // main sequence
  initial begin
    int n;
    probe_t p;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, dots, restart, ignored characters
    probes.push_back(row("x",   0, 0, 16'h0001,  0, 0, dqpb_pkg::ST_OK,  0));
    probes.push_back(row("a",   1, 1, 16'h0001, 19, 1, dqpb_pkg::ST_OK, 19));
    probes.push_back(row(".",   1, 1, 16'hFFFF, 18, 1, dqpb_pkg::ST_OK, 18));
    probes.push_back(row("a",   1, 0, 16'h0000, 13, 0, dqpb_pkg::ST_OK,  0));
    probes.push_back(row(".",   0, 0, 16'h1234, -1, 0, dqpb_pkg::ST_OK,  0));
    probes.push_back(row(".",   0, 0, 16'h5678, -1, 0, dqpb_pkg::ST_OK,  0));
    probes.push_back(row("b",   0, 0, 16'h9ABC, -1, 0, dqpb_pkg::ST_OK,  0));
    probes.push_back(row(".",   0, 1, 16'd28,    6, 1, dqpb_pkg::ST_OK, 22));
    probes.push_back(row(8'hFF, 1, 0, 16'hFFFF, 13, 0, dqpb_pkg::ST_OK,  0));
    probes.push_back(row(8'h00, 0, 0, 16'h0000, -1, 0, dqpb_pkg::ST_OK,  0));
    probes.push_back(row(8'h80, 0, 0, 16'h0F0F, -1, 0, dqpb_pkg::ST_OK,  0));
    probes.push_back(row(8'h7F, 0, 1, 16'h8000,  7, 1, dqpb_pkg::ST_OK, 22));
    probes.push_back(row("q",   1, 0, 16'h0001, 13, 0, dqpb_pkg::ST_OK,  0));
    probes.push_back(row("r",   1, 1, 16'h7FFF, 19, 1, dqpb_pkg::ST_OK, 19));
    probes.push_back(row("z",   0, 0, 16'h0001,  0, 0, dqpb_pkg::ST_OK,  0));
    probes.push_back(row(".",   1, 0, 16'h00FF, 12, 0, dqpb_pkg::ST_OK,  0));
    probes.push_back(row("c",   0, 1, 16'hFF00,  8, 1, dqpb_pkg::ST_OK, 20));
    probes.push_back(row("y",   0, 1, 16'h0001,  0, 0, dqpb_pkg::ST_OK,  0));
    for (int i = 0; i < probes.size(); i++) begin
      p = probes[i];
      if (i > 0) idle_sender();
      send_char(p.it, n);
      if (p.words >= 0 && n != p.words) begin
        $error("row %0d: word count expected %0d, got %0d", i, p.words, n);
        fail_count++;
      end
      if (p.done_typed && n > 0) begin
        if (expected_words[expected_words.size() - 1].status !== p.st ||
            expected_words[expected_words.size() - 1].packet_length !== p.plen) begin
          $error("row %0d: done word expected status %0d length %0d", i, p.st, p.plen);
          fail_count++;
        end
      end
    end

    // id wraps from the top, receiver holds off to back up the input
    write_seed(16'hFFFF);
    hold_req <= 1'b1;
    run_random(100);

    // back to back, no idling
    write_seed(16'h0000);
    calm = 1'b1;
    run_random(50);
    calm = 1'b0;

    // random seed
    write_seed(16'($urandom_range(0, 65535)));
    run_random(100);

    push <= 1'b0;
    calm = 1'b1;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
